>>> hw/rtl/keyed_blit_with_clipping_defines.svh
// Assertion macros used by the checker file of the keyed blit block.
`ifndef KEYED_BLIT_WITH_CLIPPING_DEFINES_SVH
`define KEYED_BLIT_WITH_CLIPPING_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KBC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed blit check failed");

// Next-cycle implication, disabled while reset is high.
`define KBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed blit check failed");

`endif

>>> hw/rtl/kbc_pkg.sv
// Shared types and constants of the keyed blit with clipping block.
package kbc_pkg;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int ROW_AW      = $clog2(MAX_ROWS);
   localparam int COL_AW      = $clog2(MAX_COLS);
   localparam int ADDR_W      = ROW_AW + COL_AW;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

   localparam int CSR_W       = 9;
   localparam int CSR_AW      = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = 3;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 2;

   localparam logic [8:0] ROW_SAT = 9'd511;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PASTE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_OFFSET_ROW  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_OFFSET_COL  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_DEST_ROWS   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_DEST_COLS   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_SOURCE_COLS = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_BLEND_MODE  = 3'd5;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   typedef struct packed {
      logic load;
      logic locate;
      logic read;
      logic commit;
   } cmd_type;

endpackage

>>> hw/rtl/kbc_ctrl.sv
// Sequencing state machine of the keyed blit block.
module kbc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output kbc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      commit;

   assign commit = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LOCATE;
         ST_LOCATE: state_in = ST_READ;
         ST_READ:   state_in = ST_FINISH;
         ST_FINISH: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   assign cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.locate = (state_ff == ST_LOCATE);
   assign cmd.read   = (state_ff == ST_READ);
   assign cmd.commit = commit;

endmodule

>>> hw/rtl/kbc_datapath.sv
// Datapath of the keyed blit block: registers, source counters, frame store and pixel logic.
module kbc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  kbc_pkg::cmd_type                   cmd,
   input  logic [kbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [kbc_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                               csr_we,
   input  logic [kbc_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [kbc_pkg::CSR_W-1:0]          csr_wdata,
   output logic [kbc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [kbc_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   // Configuration registers.
   logic [8:0] off_row_ff, off_col_ff, dest_rows_ff, dest_cols_ff, src_cols_ff;
   logic       blend_ff;

   // Source raster counters.
   logic [8:0] row_cnt_ff, row_cnt_in;
   logic [8:0] col_cnt_ff, col_cnt_in;

   // Item registers.
   logic [1:0]       op_ff;
   logic [7:0]       prow_ff, pcol_ff;
   kbc_pkg::pix_type src_ff;
   logic             first_ff;

   // Located position and frame store data.
   logic [kbc_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                       inside_ff, inside_in;
   kbc_pkg::pix_type           rd_ff;

   // Result registers.
   kbc_pkg::pix_type res_pix_ff;
   logic             landed_ff, clipped_ff;

   logic [31:0] store [kbc_pkg::STORE_DEPTH];

   logic               is_paste;
   logic [8:0]         eff_row, eff_col, width;
   logic signed [10:0] tgt_row, tgt_col;
   logic [9:0]         col_next;

   kbc_pkg::pix_type   new_pix, blend_pix;
   logic               new_landed, new_clipped;
   logic [8:0]         sum_r, sum_g, sum_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_row_ff   <= '0;
         off_col_ff   <= '0;
         dest_rows_ff <= '0;
         dest_cols_ff <= '0;
         src_cols_ff  <= 9'd1;
         blend_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            kbc_pkg::CSR_OFFSET_ROW:  off_row_ff   <= csr_wdata;
            kbc_pkg::CSR_OFFSET_COL:  off_col_ff   <= csr_wdata;
            kbc_pkg::CSR_DEST_ROWS:   dest_rows_ff <= csr_wdata;
            kbc_pkg::CSR_DEST_COLS:   dest_cols_ff <= csr_wdata;
            kbc_pkg::CSR_SOURCE_COLS: src_cols_ff  <= csr_wdata;
            kbc_pkg::CSR_BLEND_MODE:  blend_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser[1:0];
         first_ff <= req_tuser[2];
         prow_ff  <= req_tdata[7:0];
         pcol_ff  <= req_tdata[15:8];
         src_ff   <= {req_tdata[47:40], req_tdata[39:32], req_tdata[31:24], req_tdata[23:16]};
      end
   end

   // Target position, bounds check and counter advance.
   assign is_paste = (op_ff == kbc_pkg::OP_PASTE);
   assign eff_row  = (is_paste && first_ff) ? 9'd0 : row_cnt_ff;
   assign eff_col  = (is_paste && first_ff) ? 9'd0 : col_cnt_ff;
   assign width    = (src_cols_ff == 9'd0) ? 9'd1 : src_cols_ff;
   assign col_next = {1'b0, eff_col} + 10'd1;

   always_comb begin
      if (is_paste) begin
         tgt_row = $signed({2'b00, eff_row}) + $signed({{2{off_row_ff[8]}}, off_row_ff});
         tgt_col = $signed({2'b00, eff_col}) + $signed({{2{off_col_ff[8]}}, off_col_ff});
      end else begin
         tgt_row = $signed({3'b000, prow_ff});
         tgt_col = $signed({3'b000, pcol_ff});
      end
      inside_in = !tgt_row[10] && !tgt_col[10]
                  && (tgt_row[9:0] < {1'b0, dest_rows_ff})
                  && (tgt_col[9:0] < {1'b0, dest_cols_ff})
                  && (32'(tgt_row[9:0]) < kbc_pkg::MAX_ROWS)
                  && (32'(tgt_col[9:0]) < kbc_pkg::MAX_COLS);
      addr_in = {tgt_row[kbc_pkg::ROW_AW-1:0], tgt_col[kbc_pkg::COL_AW-1:0]};
   end

   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (cmd.locate && is_paste) begin
         if (col_next >= {1'b0, width}) begin
            col_cnt_in = 9'd0;
            row_cnt_in = (eff_row == kbc_pkg::ROW_SAT) ? eff_row : eff_row + 9'd1;
         end else begin
            col_cnt_in = col_next[8:0];
            row_cnt_in = eff_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.locate) begin
         addr_ff   <= addr_in;
         inside_ff <= inside_in;
      end
   end

   // Result pixel.
   assign sum_r = {1'b0, rd_ff.red}   + {1'b0, src_ff.red};
   assign sum_g = {1'b0, rd_ff.green} + {1'b0, src_ff.green};
   assign sum_b = {1'b0, rd_ff.blue}  + {1'b0, src_ff.blue};

   always_comb begin
      blend_pix.red   = sum_r[8:1];
      blend_pix.green = sum_g[8:1];
      blend_pix.blue  = sum_b[8:1];
      blend_pix.alpha = rd_ff.alpha;
   end

   always_comb begin
      new_pix     = '0;
      new_landed  = 1'b0;
      new_clipped = 1'b0;
      case (op_ff)
         kbc_pkg::OP_WRITE: begin
            if (inside_ff) begin
               new_pix    = src_ff;
               new_landed = 1'b1;
            end else begin
               new_clipped = 1'b1;
            end
         end
         kbc_pkg::OP_READ: begin
            if (inside_ff) begin
               new_pix = rd_ff;
            end else begin
               new_clipped = 1'b1;
            end
         end
         kbc_pkg::OP_PASTE: begin
            if (!inside_ff) begin
               new_clipped = 1'b1;
            end else if (src_ff.alpha != 8'd0) begin
               new_pix    = blend_ff ? blend_pix : src_ff;
               new_landed = 1'b1;
            end else begin
               new_pix = rd_ff;
            end
         end
         default: ;
      endcase
   end

   // Frame store: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_ff <= store[addr_ff];
      end
      if (cmd.commit && new_landed) begin
         store[addr_ff] <= new_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_pix_ff <= new_pix;
         landed_ff  <= new_landed;
         clipped_ff <= new_clipped;
      end
   end

   assign rsp_tdata = res_pix_ff;
   assign rsp_tuser = {clipped_ff, landed_ff};

endmodule

>>> hw/rtl/keyed_blit_with_clipping.sv
// An accepted request runs through the locate, frame store read and finish states in turn,
// and the response is registered at the commit; no new request is taken until that commit,
// as the steps run in turn on the single read and single write port of the frame store.
// A stalled response delays the commit; the next request is taken the cycle after the commit.
// Reset is synchronous: it clears the controller, the source counters and the configuration registers;
// the frame store is not cleared and holds undefined data until written.
module keyed_blit_with_clipping (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // pix_row, pix_col, in_red, in_green, in_blue, in_alpha
   input  logic [kbc_pkg::REQ_DATA_W-1:0] req_tdata,
   // op, first
   input  logic [kbc_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [kbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // landed, clipped
   output logic [kbc_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_we,
   input  logic [kbc_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [kbc_pkg::CSR_W-1:0]      csr_wdata
);

   kbc_pkg::cmd_type cmd;

   kbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   kbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> hw/rtl/kbc_checker.sv
// Port-level checker of the keyed blit block and its bind to the top level.
`include "keyed_blit_with_clipping_defines.svh"

module kbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [kbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [kbc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic                                               req_beat;
   logic                                               rsp_stall;
   logic [kbc_pkg::RSP_USER_W+kbc_pkg::RSP_DATA_W-1:0] rsp_word;
   logic                                               rsp_landed, rsp_clipped;

   assign req_beat    = req_tvalid && req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign rsp_landed  = rsp_tuser[0];
   assign rsp_clipped = rsp_tuser[1];

   `KBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   `KBC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_beat, !req_tready)
   `KBC_ASSERT_NOW(a_landed_not_clipped, clock, reset, rsp_tvalid, !(rsp_landed && rsp_clipped))
   `KBC_ASSERT_NOW(a_clipped_zero, clock, reset, rsp_tvalid && rsp_clipped, rsp_tdata == '0)

endmodule

bind keyed_blit_with_clipping kbc_checker u_kbc_checker (.*);
